@@ rtl/core/rfct_pkg.sv @@
package rfct_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_FLIP  = 2'd1,
		CMD_COUNT = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam int unsigned IDX_W = 10;
	localparam int unsigned CNT_W = 11;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [IDX_W-1:0] range_low;
		logic [IDX_W-1:0] range_high;
		logic             bit_value;
	} req_t;

endpackage

@@ rtl/core/rfct_if.sv @@
interface rfct_req_if;
	logic              valid;
	logic              ready;
	rfct_pkg::req_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface rfct_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rfct_pkg::CNT_W-1:0]  ones_count;
	modport source (output valid, output ones_count, input ready);
	modport sink   (input valid, input ones_count, output ready);
endinterface

@@ rtl/core/range_flip_count_tree.sv @@
// range_flip_count_tree: a row of NUM_BITS bits, cleared at reset. It takes three
// requests: load one bit, invert an inclusive range, and count the ones in a range.
// A count gives one response; the other requests give none. Bits are kept as a
// dense bitmap in a synchronous RAM one bit wide. The tree's lazy marks are not
// needed because the bits seen from outside are the same.
// After reset, a clearing pass writes every entry once, and no request is
// taken during it.
// Steps per request, from the accepting cycle on:
//   load: the bit is written at the accepting edge.
//   flip: each bit of the clipped range takes a RAM read step (S_RD) and a
//     modify/write step (S_RMW), because the single RAM port pair allows one
//     read-modify-write at a time.
//   count: a read step and an add step per bit, then the hand-off (S_RSP)
//     into the response register. An empty range goes straight back to idle
//     for a flip and straight to the hand-off for a count.
// Range fields are 10 bits, so a request touches at most 1024 bits.
// The response waits in its own output register, and a new request is accepted
// while it waits. A second count stalls in its hand-off cycle until the first
// response is taken.
module range_flip_count_tree #(
	parameter int unsigned NUM_BITS = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	rfct_req_if.sink   req,
	rfct_rsp_if.source rsp
);
	import rfct_pkg::*;

	localparam int unsigned AW = (NUM_BITS > 2) ? $clog2(NUM_BITS) : 1;
	localparam int unsigned PW = (AW > IDX_W) ? AW : IDX_W;
	localparam logic [PW:0] LAST = (PW+1)'(NUM_BITS - 1);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_RMW, S_RSP} state_t;

	state_t            state_q;
	logic [PW:0]       pos_q;   // current index
	logic [PW:0]       hi_q;    // clipped last index
	logic [CNT_W-1:0]  cnt_q;
	logic              flip_q;
	logic              rsp_vld_q;  // response register holds a count
	logic [CNT_W-1:0]  rsp_cnt_q;
	logic              rsp_load;   // finished count moves into response register
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic              wdata, rdata;
	logic [PW:0]       l_ext, r_ext, r_clip;

	assign l_ext  = (PW+1)'(req.payload.range_low);
	assign r_ext  = (PW+1)'(req.payload.range_high);
	assign r_clip = (r_ext > LAST) ? LAST : r_ext;

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_vld_q;
	assign rsp.ones_count = rsp_cnt_q;

	// hand-off when the response register is empty or drains this cycle
	assign rsp_load = (state_q == S_RSP) && (!rsp_vld_q || rsp.ready);

	// read follows pos; in S_RMW of a flip the value read at pos is inverted and written
	assign raddr = pos_q[AW-1:0];
	always_comb begin
		we    = 1'b0;
		waddr = pos_q[AW-1:0];
		wdata = 1'b0;
		if (state_q == S_CLEAR) begin
			we = 1'b1;
		end else if (state_q == S_IDLE && req.valid
				&& req.payload.cmd == CMD_LOAD && l_ext <= LAST) begin
			we    = 1'b1;
			waddr = l_ext[AW-1:0];
			wdata = req.payload.bit_value;
		end else if (state_q == S_RMW && flip_q) begin
			we    = 1'b1;
			wdata = ~rdata;
		end
	end

	rfct_ram #(.WIDTH(1), .DEPTH(NUM_BITS)) u_bits (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			pos_q     <= '0;
			hi_q      <= '0;
			cnt_q     <= '0;
			flip_q    <= 1'b0;
			rsp_vld_q <= 1'b0;
			rsp_cnt_q <= '0;
		end else begin
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
				rsp_cnt_q <= cnt_q;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (pos_q == LAST) begin
						pos_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						pos_q  <= l_ext;
						hi_q   <= r_clip;
						cnt_q  <= '0;
						flip_q <= (req.payload.cmd == CMD_FLIP);
						priority if (req.payload.cmd == CMD_FLIP
								|| req.payload.cmd == CMD_COUNT) begin
							if (l_ext > r_clip) begin
								state_q <= (req.payload.cmd == CMD_COUNT) ? S_RSP
									: S_IDLE;
							end else begin
								state_q <= S_RD;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RD: state_q <= S_RMW;
				S_RMW: begin
					cnt_q <= cnt_q + CNT_W'(rdata);
					if (pos_q == hi_q) begin
						state_q <= flip_q ? S_IDLE : S_RSP;
					end else begin
						pos_q   <= pos_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_RSP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/rfct_ram.sv @@
module rfct_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/rfct_checker.sv @@
module rfct_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [rfct_pkg::CNT_W-1:0] ones_count
);
	import rfct_pkg::*;

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({req_ready, rsp_valid})) else $error("unknown handshake");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(ones_count))
		else $error("response dropped");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ones_count <= CNT_W'(1024)) else $error("count too large");
endmodule

bind range_flip_count_tree rfct_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.ones_count(rsp.ones_count)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import rfct_pkg::*;

	localparam int unsigned NBITS = 1024;
	localparam int unsigned N_RANDOM = 1850;

	logic clk;
	logic arst_n;

	rfct_req_if req ();
	rfct_rsp_if rsp ();

	range_flip_count_tree #(.NUM_BITS(NBITS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// Clock: 12 ns period
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Predictor state: the visible bit row. The RTL keeps no tree marks, only a
	// flat bitmap, so a flat bitmap here predicts bit-exact counts.
	logic [NBITS-1:0] bit_row;
	logic [CNT_W-1:0] count_queue[$];

	int unsigned mismatches;
	bit          random_on;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          hold_off;

	// Apply one accepted request to the bit row; push the count it yields.
	function automatic void apply_request(req_t r);
		int unsigned lo;
		int unsigned hi;
		int unsigned ones;
		lo = r.range_low;
		hi = r.range_high;
		ones = 0;
		case (cmd_t'(r.cmd))
			CMD_LOAD: begin
				if (lo < NBITS)
					bit_row[lo] = r.bit_value;
			end
			CMD_FLIP: begin
				if (hi > NBITS - 1)
					hi = NBITS - 1;
				for (int unsigned i = lo; i <= hi; i++)
					bit_row[i] = ~bit_row[i];
			end
			CMD_COUNT: begin
				if (hi > NBITS - 1)
					hi = NBITS - 1;
				for (int unsigned i = lo; i <= hi; i++)
					ones += bit_row[i];
				count_queue.push_back(ones[CNT_W-1:0]);
			end
			default: ;
		endcase
	endfunction

	// Monitor: predict on every accepted request, check every accepted response
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				apply_request(req.payload);
			if (rsp.valid && rsp.ready) begin
				if (count_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response ones_count=%0d", rsp.ones_count);
				end else begin
					logic [CNT_W-1:0] want;
					want = count_queue.pop_front();
					if (want !== rsp.ones_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("count mismatch: expected %0d got %0d",
								want, rsp.ones_count);
					end
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else if (hold_off)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Long back-pressure stretch during the random part: counted in its own process
	initial begin
		hold_off = 1'b0;
		wait (random_on);
		repeat (50) @(posedge clk);
		hold_off = 1'b1;
		repeat (2000) @(posedge clk);
		hold_off = 1'b0;
	end

	// Send one request, idling before it at the current rate
	task automatic send_req(cmd_t c, int unsigned lo, int unsigned hi, bit b);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.payload <= '{cmd: c, range_low: lo[IDX_W-1:0],
			range_high: hi[IDX_W-1:0], bit_value: b};
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	typedef struct {
		cmd_t        c;
		int unsigned lo;
		int unsigned hi;
		bit          b;
		int          fixed; // expected count or -1 to use predictor only
	} row_t;

	row_t directed[] = '{
		'{CMD_COUNT, 0, 1023, 0, 0},      // fresh after reset
		'{CMD_FLIP,  0, 1023, 0, -1},     // invert everything
		'{CMD_COUNT, 0, 1023, 0, 1024},   // full range count, widest value
		'{CMD_COUNT, 5, 4, 0, 0},         // empty range counts zero
		'{CMD_FLIP,  9, 3, 0, -1},        // empty flip does nothing
		'{CMD_COUNT, 1023, 1023, 0, 1},
		'{CMD_LOAD,  0, 0, 0, -1},
		'{CMD_LOAD,  1023, 0, 0, -1},
		'{CMD_COUNT, 0, 0, 0, 0},
		'{CMD_LOAD,  512, 1023, 1, -1},
		'{CMD_NONE,  0, 1023, 1, -1},     // unused code: no response
		'{CMD_NONE,  1023, 0, 0, -1},
		'{CMD_FLIP,  1, 1022, 1, -1},
		'{CMD_COUNT, 0, 1023, 1, -1},
		'{CMD_FLIP,  1023, 1023, 0, -1},
		'{CMD_COUNT, 1000, 1023, 0, -1},
		'{CMD_LOAD,  341, 682, 1, -1},
		'{CMD_FLIP,  300, 700, 0, -1},
		'{CMD_COUNT, 340, 342, 1, -1},
		'{CMD_FLIP,  0, 1023, 0, -1},
		'{CMD_COUNT, 0, 1023, 0, -1}
	};

	task automatic random_req();
		int unsigned sel;
		int unsigned lo;
		int unsigned hi;
		sel = $urandom_range(99);
		lo = $urandom_range(1023);
		// mostly short ranges keep the run fast; some with a random end, some empty
		if ($urandom_range(19) == 0)
			hi = $urandom_range(1023);
		else if ($urandom_range(9) == 0)
			hi = (lo > 0) ? $urandom_range(lo - 1) : 0;
		else
			hi = lo + $urandom_range(40);
		if (hi > 1023)
			hi = 1023;
		if (sel < 35)
			send_req(CMD_LOAD, lo, $urandom_range(1023), $urandom_range(1));
		else if (sel < 65)
			send_req(CMD_FLIP, lo, hi, $urandom_range(1));
		else if (sel < 97)
			send_req(CMD_COUNT, lo, hi, $urandom_range(1));
		else
			send_req(CMD_NONE, lo, hi, $urandom_range(1));
	endtask

	// Let the pipeline drain: expectations gone, then a quiet tail
	task automatic drain();
		while (count_queue.size() != 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.payload = '0;
		bit_row = '0;
		mismatches = 0;
		random_on = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table; fixed expectations double-check the predictor
		foreach (directed[k]) begin
			if (directed[k].fixed >= 0 && directed[k].c == CMD_COUNT) begin
				int unsigned ones;
				ones = 0;
				for (int unsigned i = directed[k].lo;
					i <= directed[k].hi && i < NBITS; i++)
					ones += bit_row[i];
				if (ones != directed[k].fixed) begin
					mismatches++;
					if (mismatches <= 10)
						$display("row %0d: expected %0d predicted %0d",
							k, directed[k].fixed, ones);
				end
			end
			send_req(directed[k].c, directed[k].lo, directed[k].hi, directed[k].b);
		end

		// Random part in three idling phases
		random_on = 1'b1;
		send_idle_pct = 25;
		recv_idle_pct = 60;
		repeat (N_RANDOM / 3) random_req();
		send_idle_pct = 60;
		recv_idle_pct = 25;
		repeat (N_RANDOM / 3) random_req();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (N_RANDOM - 2 * (N_RANDOM / 3)) random_req();
		req.valid <= 1'b0;

		drain();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#30ms;
		$display("FAIL");
		$finish;
	end

endmodule
